>>> sv/bmhpq_pkg.sv
// Package for the binary max-heap priority queue core.
// Holds sizes, status codes and the sequencer state type; no dependencies.
package bmhpq_pkg;

    localparam int HEAP_DEPTH_DEF   = 64;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int PRIO_W           = 16;
    localparam int STATUS_W         = 2;
    localparam int OUT_PAY_W        = 32;
    localparam int OUT_CNT_W        = 7;
    localparam int OUT_DATA_W       = 56;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ_RD,
        ST_ENQ_CMP,
        ST_DQ_ROOT,
        ST_DQ_LAST,
        ST_DN_CHK,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_DONE
    } t_state;

endpackage

>>> sv/bmhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the heap entry store; no dependencies.
module bmhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/binary_max_heap_priority_queue_core.sv
// Top level of the binary max-heap priority queue core.
// Depends on bmhpq_pkg and bmhpq_ram (heap entry store).
//
//  channel   direction  tdata (low bit up)                          tuser
//  s_axis    in         payload_in, prio_in                         func
//  m_axis    out        payload_out, prio_out, entry_count, is_empty status
//
// An enqueue reads each parent in turn and moves it down while the new item's priority
// is greater. A dequeue reads the root, then the last entry, and sinks that entry,
// reading the left and right child and comparing at each level; removing the only entry
// skips the sink. A dequeue on an empty heap or an enqueue on a full heap only reports status.
// The single RAM read port and the one shared priority comparator make these steps run in turn.
// Reset clears only the entry count and the handshake state; the store needs no clearing.
// The input is taken only while the sequencer idles; a finished result waits in the
// output register, and the next item is taken meanwhile. A result that finds the
// output register still full holds the sequencer until the waiting item moves out.
module binary_max_heap_priority_queue_core #(
    parameter int HEAP_DEPTH   = bmhpq_pkg::HEAP_DEPTH_DEF,
    parameter int PAYLOAD_BITS = bmhpq_pkg::PAYLOAD_BITS_DEF,
    localparam int IN_DATA_W   = ((PAYLOAD_BITS + bmhpq_pkg::PRIO_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // payload_in, prio_in
    input  logic [IN_DATA_W-1:0]              s_axis_tdata,
    // func
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // payload_out, prio_out, entry_count, is_empty
    output logic [bmhpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [bmhpq_pkg::STATUS_W-1:0]    m_axis_tuser
);

    localparam int PW    = bmhpq_pkg::PRIO_W;
    localparam int AW    = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int IW    = CNT_W + 1;
    localparam int EW    = PW + PAYLOAD_BITS;

    bmhpq_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]               r_count, n_count;
    logic [AW-1:0]                  r_pos, n_pos;
    logic [AW-1:0]                  r_cidx, n_cidx;
    logic [EW-1:0]                  r_item, n_item;
    logic [EW-1:0]                  r_child, n_child;
    logic [bmhpq_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [PAYLOAD_BITS-1:0]        r_res_pay, n_res_pay;
    logic [PW-1:0]                  r_res_prio, n_res_prio;

    logic                                r_ovalid, n_ovalid;
    logic [bmhpq_pkg::STATUS_W-1:0]      r_o_status, n_o_status;
    logic [bmhpq_pkg::OUT_PAY_W-1:0]     r_o_pay, n_o_pay;
    logic [PW-1:0]                       r_o_prio, n_o_prio;
    logic [bmhpq_pkg::OUT_CNT_W-1:0]     r_o_count, n_o_count;
    logic                                r_o_empty, n_o_empty;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic signed [PW-1:0] cmp_a, cmp_b;
    logic                 cmp_gt;

    logic [AW-1:0] pos_m1;
    logic [AW-1:0] parent;
    logic [IW-1:0] child;
    logic [IW-1:0] right;
    logic [IW-1:0] count_x;
    logic [63:0]   pay_x;

    bmhpq_ram #(
        .WIDTH (EW),
        .DEPTH (HEAP_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cmp_gt  = cmp_a > cmp_b;
    assign pos_m1  = r_pos - 1'b1;
    assign parent  = AW'(pos_m1 >> 1);
    assign child   = IW'({r_pos, 1'b1});
    assign right   = IW'(r_cidx) + 1'b1;
    assign count_x = IW'(r_count);
    assign pay_x   = 64'(r_res_pay);

    assign s_axis_tready = (r_state == bmhpq_pkg::ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_cidx       = r_cidx;
        n_item       = r_item;
        n_child      = r_child;
        n_res_status = r_res_status;
        n_res_pay    = r_res_pay;
        n_res_prio   = r_res_prio;
        n_ovalid     = r_ovalid;
        n_o_status   = r_o_status;
        n_o_pay      = r_o_pay;
        n_o_prio     = r_o_prio;
        n_o_count    = r_o_count;
        n_o_empty    = r_o_empty;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_item;
        ram_raddr    = '0;
        cmp_a        = r_item[EW-1 -: PW];
        cmp_b        = ram_rdata[EW-1 -: PW];

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            bmhpq_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_status = bmhpq_pkg::STATUS_OK;
                    n_res_pay    = '0;
                    n_res_prio   = '0;
                    n_pos        = '0;
                    if (s_axis_tuser[0] == bmhpq_pkg::FUNC_ENQ) begin
                        if (count_x >= IW'(HEAP_DEPTH)) begin
                            n_res_status = bmhpq_pkg::STATUS_FULL;
                            n_state      = bmhpq_pkg::ST_DONE;
                        end else begin
                            n_item  = {s_axis_tdata[PAYLOAD_BITS +: PW],
                                       s_axis_tdata[PAYLOAD_BITS-1:0]};
                            n_pos   = AW'(r_count);
                            n_count = r_count + 1'b1;
                            n_state = bmhpq_pkg::ST_ENQ_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = bmhpq_pkg::STATUS_EMPTY;
                            n_state      = bmhpq_pkg::ST_DONE;
                        end else begin
                            ram_raddr = '0;
                            n_state   = bmhpq_pkg::ST_DQ_ROOT;
                        end
                    end
                end
            end
            bmhpq_pkg::ST_ENQ_RD: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = bmhpq_pkg::ST_DONE;
                end else begin
                    ram_raddr = parent;
                    n_cidx    = parent;
                    n_state   = bmhpq_pkg::ST_ENQ_CMP;
                end
            end
            bmhpq_pkg::ST_ENQ_CMP: begin
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                    n_pos     = r_cidx;
                    n_state   = bmhpq_pkg::ST_ENQ_RD;
                end else begin
                    n_state = bmhpq_pkg::ST_DONE;
                end
            end
            bmhpq_pkg::ST_DQ_ROOT: begin
                n_res_pay  = ram_rdata[PAYLOAD_BITS-1:0];
                n_res_prio = ram_rdata[EW-1 -: PW];
                if (r_count == CNT_W'(1)) begin
                    n_count = '0;
                    n_state = bmhpq_pkg::ST_DONE;
                end else begin
                    ram_raddr = AW'(r_count - 1'b1);
                    n_state   = bmhpq_pkg::ST_DQ_LAST;
                end
            end
            bmhpq_pkg::ST_DQ_LAST: begin
                n_item  = ram_rdata;
                n_count = r_count - 1'b1;
                n_pos   = '0;
                n_state = bmhpq_pkg::ST_DN_CHK;
            end
            bmhpq_pkg::ST_DN_CHK: begin
                if (child >= count_x) begin
                    ram_we  = 1'b1;
                    n_state = bmhpq_pkg::ST_DONE;
                end else begin
                    ram_raddr = AW'(child);
                    n_cidx    = AW'(child);
                    n_state   = bmhpq_pkg::ST_DN_LEFT;
                end
            end
            bmhpq_pkg::ST_DN_LEFT: begin
                n_child = ram_rdata;
                if (right < count_x) begin
                    ram_raddr = AW'(right);
                    n_state   = bmhpq_pkg::ST_DN_RIGHT;
                end else begin
                    n_state = bmhpq_pkg::ST_DN_CMP;
                end
            end
            bmhpq_pkg::ST_DN_RIGHT: begin
                cmp_a = ram_rdata[EW-1 -: PW];
                cmp_b = r_child[EW-1 -: PW];
                if (cmp_gt) begin
                    n_child = ram_rdata;
                    n_cidx  = AW'(right);
                end
                n_state = bmhpq_pkg::ST_DN_CMP;
            end
            bmhpq_pkg::ST_DN_CMP: begin
                cmp_a  = r_child[EW-1 -: PW];
                cmp_b  = r_item[EW-1 -: PW];
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = r_child;
                    n_pos     = r_cidx;
                    n_state   = bmhpq_pkg::ST_DN_CHK;
                end else begin
                    n_state = bmhpq_pkg::ST_DONE;
                end
            end
            bmhpq_pkg::ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_res_status;
                    n_o_pay    = pay_x[bmhpq_pkg::OUT_PAY_W-1:0];
                    n_o_prio   = r_res_prio;
                    n_o_count  = bmhpq_pkg::OUT_CNT_W'(32'(r_count));
                    n_o_empty  = (r_count == '0);
                    n_state    = bmhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bmhpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bmhpq_pkg::ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cidx       <= n_cidx;
        r_item       <= n_item;
        r_child      <= n_child;
        r_res_status <= n_res_status;
        r_res_pay    <= n_res_pay;
        r_res_prio   <= n_res_prio;
        r_o_status   <= n_o_status;
        r_o_pay      <= n_o_pay;
        r_o_prio     <= n_o_prio;
        r_o_count    <= n_o_count;
        r_o_empty    <= n_o_empty;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_o_empty, r_o_count, r_o_prio, r_o_pay};
    assign m_axis_tuser  = r_o_status;

endmodule

>>> dv/tb_binary_max_heap_priority_queue_core.sv
// Self-checking testbench for binary_max_heap_priority_queue_core.
// Compares each result item against a behavioral max-heap predictor;
// depends on bmhpq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_binary_max_heap_priority_queue_core;

    localparam int DEPTH = bmhpq_pkg::HEAP_DEPTH_DEF;
    localparam int PW    = bmhpq_pkg::PRIO_W;
    localparam int SW    = bmhpq_pkg::STATUS_W;
    localparam int CW    = bmhpq_pkg::OUT_CNT_W;
    localparam int ODW   = bmhpq_pkg::OUT_DATA_W;

    typedef struct packed {
        logic [SW-1:0] status;
        logic [31:0]   payload;
        logic [PW-1:0] prio;
        logic [CW-1:0] count;
        logic          empty;
    } t_heap_result;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [47:0]            s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [ODW-1:0]         m_axis_tdata;
    logic [SW-1:0]          m_axis_tuser;

    logic signed [PW-1:0] heap_prio [DEPTH];
    logic [31:0]          heap_pay [DEPTH];
    int                   heap_fill = 0;

    t_heap_result pending_results[$];
    t_heap_result oldest_result;
    int           err_count = 0;
    bit           burst_mode = 1'b0;

    binary_max_heap_priority_queue_core #(
        .HEAP_DEPTH   (DEPTH),
        .PAYLOAD_BITS (bmhpq_pkg::PAYLOAD_BITS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_binary_max_heap_priority_queue_core: FAIL");
        $finish;
    end

    function automatic t_heap_result heap_apply(input logic func, input logic [31:0] pay,
                                                input logic signed [PW-1:0] pr);
        t_heap_result         r;
        int                   pos;
        int                   parent;
        int                   c;
        int                   last;
        logic signed [PW-1:0] p;
        logic [31:0]          d;
        r = '0;
        if (func == bmhpq_pkg::FUNC_ENQ) begin
            if (heap_fill >= DEPTH) begin
                r.status = bmhpq_pkg::STATUS_FULL;
            end else begin
                pos = heap_fill;
                heap_fill++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!(pr > heap_prio[parent])) break;
                    heap_prio[pos] = heap_prio[parent];
                    heap_pay[pos]  = heap_pay[parent];
                    pos = parent;
                end
                heap_prio[pos] = pr;
                heap_pay[pos]  = pay;
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = bmhpq_pkg::STATUS_EMPTY;
            end else begin
                r.payload = heap_pay[0];
                r.prio    = heap_prio[0];
                last      = heap_fill - 1;
                p         = heap_prio[last];
                d         = heap_pay[last];
                heap_fill = last;
                pos       = 0;
                while (2 * pos + 1 < heap_fill) begin
                    c = 2 * pos + 1;
                    if (c + 1 < heap_fill && heap_prio[c] < heap_prio[c + 1]) c++;
                    if (p >= heap_prio[c]) break;
                    heap_prio[pos] = heap_prio[c];
                    heap_pay[pos]  = heap_pay[c];
                    pos = c;
                end
                if (heap_fill > 0) begin
                    heap_prio[pos] = p;
                    heap_pay[pos]  = d;
                end
            end
        end
        r.count = heap_fill[CW-1:0];
        r.empty = (heap_fill == 0);
        return r;
    endfunction

    function automatic logic [PW-1:0] draw_prio(input int cls);
        logic [PW-1:0] v;
        case (cls)
            0: begin
                v = PW'($urandom_range(0, 8) - 4);
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            default: begin
                v = PW'($urandom);
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input logic func, input logic [31:0] pay,
                             input logic [PW-1:0] pr);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pr, pay};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(heap_apply(func, pay, pr));
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
                err_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("status", 32'(oldest_result.status), 32'(m_axis_tuser));
                check_field("payload_out", oldest_result.payload, m_axis_tdata[31:0]);
                check_field("prio_out", 32'(oldest_result.prio), 32'(m_axis_tdata[47:32]));
                check_field("entry_count", 32'(oldest_result.count), 32'(m_axis_tdata[54:48]));
                check_field("is_empty", 32'(oldest_result.empty), 32'(m_axis_tdata[55]));
            end
        end
    end

    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic test_empty_dequeue();
        send_item(bmhpq_pkg::FUNC_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(bmhpq_pkg::FUNC_DEQ, 32'h0000_0000, 16'h0000);
        wait_results_done();
    endtask

    task automatic test_extremes_and_ties();
        send_item(bmhpq_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 16'h7FFF);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h0000_0000, 16'h8000);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h1234_5678, 16'h0000);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h8000_0001, 16'hFFFF);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h7FFF_FFFE, 16'h0001);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h0000_00A1, 16'h0064);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h0000_00A2, 16'h0064);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h0000_00A3, 16'h0064);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h0000_0055, 16'h8000);
        send_item(bmhpq_pkg::FUNC_ENQ, 32'h0000_00AA, 16'h7FFF);
        repeat (11) send_item(bmhpq_pkg::FUNC_DEQ, $urandom, PW'($urandom));
        wait_results_done();
    endtask

    task automatic test_full_heap();
        repeat (DEPTH) send_item(bmhpq_pkg::FUNC_ENQ, $urandom,
                                 draw_prio($urandom_range(0, 2)));
        send_item(bmhpq_pkg::FUNC_ENQ, 32'hDEAD_BEEF, 16'h7FFF);
        send_item(bmhpq_pkg::FUNC_ENQ, $urandom, PW'($urandom));
        wait_results_done();
        repeat (DEPTH + 1) send_item(bmhpq_pkg::FUNC_DEQ, $urandom, PW'($urandom));
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int num_phases);
        int  mode;
        int  cls;
        int  enq_pct;
        logic func;
        for (int ph = 0; ph < num_phases; ph++) begin
            mode = $urandom_range(0, 2);
            cls = $urandom_range(0, 2);
            burst_mode = ($urandom_range(0, 3) == 0);
            enq_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 50;
            repeat (50) begin
                func = ($urandom_range(1, 100) <= enq_pct) ? bmhpq_pkg::FUNC_ENQ
                                                            : bmhpq_pkg::FUNC_DEQ;
                send_item(func, $urandom, draw_prio(cls));
            end
            if ($urandom_range(0, 4) == 0) wait_results_done();
        end
        burst_mode = 1'b0;
        wait_results_done();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_dequeue();
        test_extremes_and_ties();
        test_full_heap();
        test_random_traffic(20);
        wait_results_done();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb_binary_max_heap_priority_queue_core: PASS");
        end else begin
            $display("tb_binary_max_heap_priority_queue_core: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/bmhpq_pkg.sv
sv/bmhpq_ram.sv
sv/binary_max_heap_priority_queue_core.sv
dv/tb_binary_max_heap_priority_queue_core.sv
